// ----- design/two_digit_seven_segment_driver_assert.svh -----
// Assertion macros shared by the display driver modules.
`ifndef TWO_DIGIT_SEVEN_SEGMENT_DRIVER_ASSERT_SVH
`define TWO_DIGIT_SEVEN_SEGMENT_DRIVER_ASSERT_SVH

`ifndef SYNTH

// Clocked assertion that is switched off while reset is asserted.
`define TSD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("display driver assertion failed");

// Clocked assertion that also holds during reset.
`define TSD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("display driver assertion failed");

`else

`define TSD_ASSERT(lbl, clk, rst_n, prop)
`define TSD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- design/tsd_pkg.sv -----
// Types, codes, glyphs and the helper function of the two-digit display driver.
package tsd_pkg;

    // Item modes.
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CURRENT = 3'd1;
    localparam logic [2:0] MODE_STATUS  = 3'd2;
    localparam logic [2:0] MODE_PAIRING = 3'd3;
    localparam logic [2:0] MODE_DECIMAL = 3'd4;
    localparam logic [2:0] MODE_RAW     = 3'd5;

    // System status codes.
    localparam logic [15:0] STATUS_STOP      = 16'd0;
    localparam logic [15:0] STATUS_HALT      = 16'd1;
    localparam logic [15:0] STATUS_GO        = 16'd2;
    localparam logic [15:0] STATUS_SHORT     = 16'd3;
    localparam logic [15:0] STATUS_TESTDRIVE = 16'd4;
    localparam logic [15:0] STATUS_RESET     = 16'd5;
    localparam logic [15:0] STATUS_OVERTEMP  = 16'd6;

    // Status and pairing glyphs, gfedcba with bit 7 as the point.
    localparam logic [7:0] GLYPH_S      = 8'b0110_1101;
    localparam logic [7:0] GLYPH_T_DOT  = 8'b1111_1000;
    localparam logic [7:0] GLYPH_BAR_L  = 8'b0000_0110;
    localparam logic [7:0] GLYPH_BAR_R  = 8'b0011_0000;
    localparam logic [7:0] GLYPH_H      = 8'b0111_0110;
    localparam logic [7:0] GLYPH_T      = 8'b0111_1000;
    localparam logic [7:0] GLYPH_D      = 8'b0101_1110;
    localparam logic [7:0] GLYPH_R      = 8'b0101_0000;
    localparam logic [7:0] GLYPH_E      = 8'b0111_1001;
    localparam logic [7:0] GLYPH_O      = 8'b0101_1100;
    localparam logic [7:0] GLYPH_A      = 8'b0111_0111;
    localparam logic [7:0] GLYPH_P      = 8'b0111_0011;

    localparam logic [7:0] POINT_BIT    = 8'h80;
    localparam logic [11:0] BLINK_PERIOD_RESET = 12'd600;

    // Digit enable bit positions.
    localparam int EN_LEFT  = 0;
    localparam int EN_RIGHT = 1;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] value;
        logic               dp;
        logic               pairing_on;
        logic               track_is_go;
        logic [7:0]         left_pattern;
        logic [7:0]         right_pattern;
    } item_t;

    function automatic logic [7:0] dec_glyph(input logic [3:0] digit);
        logic [7:0] g;
        unique case (digit)
            4'd0:    g = 8'h3F;
            4'd1:    g = 8'h06;
            4'd2:    g = 8'h5B;
            4'd3:    g = 8'h4F;
            4'd4:    g = 8'h66;
            4'd5:    g = 8'h6D;
            4'd6:    g = 8'h7D;
            4'd7:    g = 8'h07;
            4'd8:    g = 8'h7F;
            4'd9:    g = 8'h6F;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// ----- design/tsd_decimal.sv -----
// Clamps a signed number to 0..99 and forms the two digit glyph bytes.
module tsd_decimal (
    input  logic signed [15:0] value,
    input  logic               point,
    output logic [7:0]         left_byte,
    output logic [7:0]         right_byte
);

    logic [6:0]  clamped;
    logic [14:0] scaled;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  ones_wide;
    logic [3:0]  ones;

    always_comb begin
        if (value < 16'sd0) begin
            clamped = 7'd0;
        end else if (value > 16'sd99) begin
            clamped = 7'd99;
        end else begin
            clamped = value[6:0];
        end
    end

    // 205/2048 approximates 1/10 exactly enough for values below 180.
    assign scaled    = 15'(clamped) * 15'd205;
    assign tens      = scaled[14:11];
    assign tens_x10  = 7'(tens) * 7'd10;
    assign ones_wide = clamped - tens_x10;
    assign ones      = ones_wide[3:0];

    always_comb begin
        if (tens == 4'd0 && !point) begin
            left_byte = 8'h00;
        end else begin
            left_byte = tsd_pkg::dec_glyph(tens) | (point ? tsd_pkg::POINT_BIT : 8'h00);
        end
    end

    assign right_byte = tsd_pkg::dec_glyph(ones);

endmodule

// ----- design/tsd_core.sv -----
// Display state, tick multiplexer and blink logic; its state is the result payload.
`include "two_digit_seven_segment_driver_assert.svh"

module tsd_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  tsd_pkg::item_t      item,
    input  logic                cfg_wr_en,
    input  logic [11:0]         cfg_wr_data,
    output logic [7:0]          segment_lines,
    output logic                left_enable,
    output logic                right_enable
);

    logic [11:0] blink_period_reg;
    logic [2:0]  mux_count_reg,   mux_count_next;
    logic [11:0] blink_phase_reg, blink_phase_next;
    logic        blinking_reg,    blinking_next;
    logic        show_value_reg,  show_value_next;
    logic [7:0]  left_byte_reg,   left_byte_next;
    logic [7:0]  right_byte_reg,  right_byte_next;
    logic [7:0]  line_hold_reg,   line_hold_next;
    logic [1:0]  enables_reg,     enables_next;

    logic [7:0]  dec_left;
    logic [7:0]  dec_right;
    logic        dec_point;
    logic        blank;
    logic [12:0] phase_inc;

    assign dec_point = (item.mode == tsd_pkg::MODE_CURRENT) ? 1'b1 : item.dp;

    tsd_decimal u_decimal (
        .value      (item.value),
        .point      (dec_point),
        .left_byte  (dec_left),
        .right_byte (dec_right)
    );

    assign blank     = blinking_reg && (blink_phase_reg < {1'b0, blink_period_reg[11:1]});
    assign phase_inc = {1'b0, blink_phase_reg} + 13'd1;

    always_comb begin
        mux_count_next   = mux_count_reg;
        blink_phase_next = blink_phase_reg;
        blinking_next    = blinking_reg;
        show_value_next  = show_value_reg;
        left_byte_next   = left_byte_reg;
        right_byte_next  = right_byte_reg;
        line_hold_next   = line_hold_reg;
        enables_next     = enables_reg;

        unique case (item.mode)
            tsd_pkg::MODE_TICK: begin
                if (blank || mux_count_reg == 3'd0 || mux_count_reg == 3'd4) begin
                    enables_next = 2'b00;
                end else if (!mux_count_reg[2]) begin
                    line_hold_next = left_byte_reg;
                    enables_next   = 2'b01;
                end else begin
                    line_hold_next = right_byte_reg;
                    enables_next   = 2'b10;
                end
                mux_count_next = mux_count_reg + 3'd1;
                if (phase_inc >= {1'b0, blink_period_reg}) begin
                    blink_phase_next = 12'd0;
                end else begin
                    blink_phase_next = phase_inc[11:0];
                end
            end
            tsd_pkg::MODE_CURRENT: begin
                if (show_value_reg) begin
                    left_byte_next  = dec_left;
                    right_byte_next = dec_right;
                end
            end
            tsd_pkg::MODE_STATUS: begin
                show_value_next = 1'b0;
                priority if (item.value == tsd_pkg::STATUS_STOP) begin
                    left_byte_next  = tsd_pkg::GLYPH_S;
                    right_byte_next = tsd_pkg::GLYPH_T_DOT;
                end else if (item.value == tsd_pkg::STATUS_HALT) begin
                    left_byte_next  = tsd_pkg::GLYPH_BAR_L;
                    right_byte_next = tsd_pkg::GLYPH_BAR_R;
                end else if (item.value == tsd_pkg::STATUS_GO) begin
                    show_value_next = 1'b1;
                end else if (item.value == tsd_pkg::STATUS_SHORT) begin
                    left_byte_next  = tsd_pkg::GLYPH_S;
                    right_byte_next = tsd_pkg::GLYPH_H;
                end else if (item.value == tsd_pkg::STATUS_TESTDRIVE) begin
                    left_byte_next  = tsd_pkg::GLYPH_T;
                    right_byte_next = tsd_pkg::GLYPH_D;
                end else if (item.value == tsd_pkg::STATUS_RESET) begin
                    left_byte_next  = tsd_pkg::GLYPH_R;
                    right_byte_next = tsd_pkg::GLYPH_E;
                end else if (item.value == tsd_pkg::STATUS_OVERTEMP) begin
                    left_byte_next  = tsd_pkg::GLYPH_O;
                    right_byte_next = tsd_pkg::GLYPH_T;
                end else begin
                    show_value_next = 1'b0;
                end
            end
            tsd_pkg::MODE_PAIRING: begin
                if (item.pairing_on) begin
                    show_value_next = 1'b0;
                    blinking_next   = 1'b1;
                    left_byte_next  = tsd_pkg::GLYPH_P;
                    right_byte_next = tsd_pkg::GLYPH_A;
                end else begin
                    show_value_next = item.track_is_go;
                    blinking_next   = 1'b0;
                end
            end
            tsd_pkg::MODE_DECIMAL: begin
                left_byte_next  = dec_left;
                right_byte_next = dec_right;
            end
            tsd_pkg::MODE_RAW: begin
                left_byte_next  = item.left_pattern;
                right_byte_next = item.right_pattern;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_period_reg <= tsd_pkg::BLINK_PERIOD_RESET;
        end else if (cfg_wr_en) begin
            blink_period_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mux_count_reg   <= 3'd0;
            blink_phase_reg <= 12'd0;
            blinking_reg    <= 1'b0;
            show_value_reg  <= 1'b0;
            left_byte_reg   <= 8'h00;
            right_byte_reg  <= 8'h00;
            line_hold_reg   <= 8'h00;
            enables_reg     <= 2'b00;
        end else if (advance) begin
            mux_count_reg   <= mux_count_next;
            blink_phase_reg <= blink_phase_next;
            blinking_reg    <= blinking_next;
            show_value_reg  <= show_value_next;
            left_byte_reg   <= left_byte_next;
            right_byte_reg  <= right_byte_next;
            line_hold_reg   <= line_hold_next;
            enables_reg     <= enables_next;
        end
    end

    assign segment_lines = line_hold_reg;
    assign left_enable   = enables_reg[tsd_pkg::EN_LEFT];
    assign right_enable  = enables_reg[tsd_pkg::EN_RIGHT];

    `TSD_ASSERT(a_off_slot_dark, aclk, aresetn,
        (advance && item.mode == tsd_pkg::MODE_TICK && mux_count_reg[1:0] == 2'd0)
        |=> (enables_reg == 2'b00))
    `TSD_ASSERT(a_blank_dark, aclk, aresetn,
        (advance && item.mode == tsd_pkg::MODE_TICK && blank) |=> (enables_reg == 2'b00))
    `TSD_ASSERT(a_non_tick_holds, aclk, aresetn,
        (advance && item.mode != tsd_pkg::MODE_TICK)
        |=> ($stable(line_hold_reg) && $stable(enables_reg) && $stable(mux_count_reg)))
    `TSD_ASSERT(a_idle_holds, aclk, aresetn,
        !advance |=> ($stable(line_hold_reg) && $stable(enables_reg)))

endmodule

// ----- design/two_digit_seven_segment_driver.sv -----
// Top level of the two-digit multiplexed seven-segment display driver.
//
// Each input transfer carries one command (a mux tick, a value, a status, the pairing
// indication, a decimal or a raw write) and produces exactly one output transfer that
// reports the segment lines and the two digit enables after that command. The block
// takes one transfer every clock cycle while the downstream side takes every result.
// An accepted command lands in the input register, and the single-pass state update
// then moves it into the display state, which is the output register, as soon as the
// result slot is free. m_ready reaches s_ready combinationally, so a full pipeline keeps
// moving whenever the downstream side takes a result. The blink period register may be
// written at any time the driver is idle; it takes effect on the next tick.

`include "two_digit_seven_segment_driver_assert.svh"

module two_digit_seven_segment_driver (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic signed [15:0] s_value,
    input  logic               s_dp,
    input  logic               s_pairing_on,
    input  logic               s_track_is_go,
    input  logic [7:0]         s_left_pattern,
    input  logic [7:0]         s_right_pattern,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_segment_lines,
    output logic               m_left_enable,
    output logic               m_right_enable,

    input  logic               cfg_wr_en,
    input  logic [11:0]        cfg_wr_data
);

    // Input register: one command waiting for the state update.
    logic           in_vld_reg;
    tsd_pkg::item_t item_reg;

    // Result valid; the payload is the display state held inside the core.
    logic           m_valid_reg;

    logic           advance;
    logic           s_fire;

    // The held command moves into the state when the result slot is free or is being
    // emptied in this same cycle.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    // Payload needs no reset; it is qualified by in_vld_reg.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.mode          <= s_mode;
            item_reg.value         <= s_value;
            item_reg.dp            <= s_dp;
            item_reg.pairing_on    <= s_pairing_on;
            item_reg.track_is_go   <= s_track_is_go;
            item_reg.left_pattern  <= s_left_pattern;
            item_reg.right_pattern <= s_right_pattern;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    // The display state only changes on advance, so a stalled result stays put.
    tsd_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .item          (item_reg),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .segment_lines (m_segment_lines),
        .left_enable   (m_left_enable),
        .right_enable  (m_right_enable)
    );

    // Every state update must leave a result for the downstream side.
    `TSD_ASSERT(a_advance_gives_result, aclk, aresetn, advance |=> m_valid_reg)
    // A command never overruns the held one before it has moved on.
    `TSD_ASSERT(a_no_overrun, aclk, aresetn, (in_vld_reg && !advance) |-> !s_ready)
    // A stalled result is never replaced by a new state update.
    `TSD_ASSERT(a_no_result_overwrite, aclk, aresetn,
        (m_valid_reg && !m_ready) |-> !advance)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the two-digit seven-segment display driver.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tsd_pkg::*;

    // The package names the six modes and seven status codes. The spare modes and
    // the catch-all status code are named here so that they never appear as bare numbers.
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
    localparam logic [15:0] STATUS_OTHER = 16'd7;

    localparam int NUM_PHASES      = 8;
    localparam int PHASE_ITEMS     = 180;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int HOLD_OFF_ITEM   = 60;

    // One output transfer: the segment lines and the two digit commons.
    typedef struct packed {
        logic [7:0] lines;
        logic       left_en;
        logic       right_en;
    } display_out_t;

    // One row of the directed table. When typed is set, want is the value to expect.
    // Otherwise the display model supplies the expected value.
    typedef struct packed {
        item_t        cmd;
        logic         typed;
        display_out_t want;
    } directed_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_mode;
    logic signed [15:0] s_value;
    logic               s_dp;
    logic               s_pairing_on;
    logic               s_track_is_go;
    logic [7:0]         s_left_pattern;
    logic [7:0]         s_right_pattern;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_segment_lines;
    logic               m_left_enable;
    logic               m_right_enable;
    logic               cfg_wr_en;
    logic [11:0]        cfg_wr_data;

    two_digit_seven_segment_driver uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_value         (s_value),
        .s_dp            (s_dp),
        .s_pairing_on    (s_pairing_on),
        .s_track_is_go   (s_track_is_go),
        .s_left_pattern  (s_left_pattern),
        .s_right_pattern (s_right_pattern),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segment_lines (m_segment_lines),
        .m_left_enable   (m_left_enable),
        .m_right_enable  (m_right_enable),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    // The display model: its own copy of the blink period and of every state register.
    logic [11:0] period_m;
    logic [2:0]  mux_m;
    logic [11:0] phase_m;
    logic        blink_m;
    logic        show_m;
    logic [7:0]  left_m;
    logic [7:0]  right_m;
    logic [7:0]  lines_m;
    logic        left_on_m;
    logic        right_on_m;

    logic [7:0] digit_segments [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    // Display outputs that are still to come, oldest first.
    display_out_t pending_outputs[$];
    directed_row_t directed_rows[$];

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int cfg_writes    = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // The clock has a 12 ns period.
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Every input has a known value from time zero.
    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = MODE_TICK;
        s_value         = '0;
        s_dp            = 1'b0;
        s_pairing_on    = 1'b0;
        s_track_is_go   = 1'b0;
        s_left_pattern  = '0;
        s_right_pattern = '0;
        m_ready         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        period_m        = BLINK_PERIOD_RESET;
        mux_m           = '0;
        phase_m         = '0;
        blink_m         = 1'b0;
        show_m          = 1'b0;
        left_m          = '0;
        right_m         = '0;
        lines_m         = '0;
        left_on_m       = 1'b0;
        right_on_m      = 1'b0;
    end

    // A decimal write clamps to 0..99. The tens digit is blank when it is zero and no
    // point is asked for.
    task automatic load_decimal(input logic signed [15:0] v, input logic point);
        int n;
        n = v;
        if (n > 99) n = 99;
        if (n < 0) n = 0;
        if (n / 10 == 0 && !point) begin
            left_m = 8'h00;
        end else begin
            left_m = digit_segments[n / 10] | (point ? POINT_BIT : 8'h00);
        end
        right_m = digit_segments[n % 10];
    endtask

    // Advances the display model by one command and returns the outputs that follow it.
    task automatic predict_display(input item_t c, output display_out_t r);
        int   next_phase;
        logic blank;
        case (c.mode)
            MODE_TICK: begin
                // A blinking display also blanks the first half of every blink period.
                blank = blink_m && (phase_m < (period_m >> 1));
                if (blank || mux_m == 3'd0 || mux_m == 3'd4) begin
                    left_on_m  = 1'b0;
                    right_on_m = 1'b0;
                end else if (mux_m < 3'd4) begin
                    lines_m    = left_m;
                    left_on_m  = 1'b1;
                    right_on_m = 1'b0;
                end else begin
                    lines_m    = right_m;
                    left_on_m  = 1'b0;
                    right_on_m = 1'b1;
                end
                mux_m = mux_m + 3'd1;
                // The phase wraps even after the period has been lowered below it.
                next_phase = int'(phase_m) + 1;
                phase_m = (next_phase >= int'(period_m)) ? 12'd0 : 12'(next_phase);
            end
            MODE_CURRENT: begin
                if (show_m) load_decimal(c.value, 1'b1);
            end
            MODE_STATUS: begin
                show_m = 1'b0;
                case (c.value)
                    STATUS_STOP:      begin left_m = GLYPH_S;     right_m = GLYPH_T_DOT; end
                    STATUS_HALT:      begin left_m = GLYPH_BAR_L; right_m = GLYPH_BAR_R; end
                    STATUS_GO:        show_m = 1'b1;
                    STATUS_SHORT:     begin left_m = GLYPH_S;     right_m = GLYPH_H;     end
                    STATUS_TESTDRIVE: begin left_m = GLYPH_T;     right_m = GLYPH_D;     end
                    STATUS_RESET:     begin left_m = GLYPH_R;     right_m = GLYPH_E;     end
                    STATUS_OVERTEMP:  begin left_m = GLYPH_O;     right_m = GLYPH_T;     end
                    default: ;
                endcase
            end
            MODE_PAIRING: begin
                if (c.pairing_on) begin
                    show_m  = 1'b0;
                    blink_m = 1'b1;
                    left_m  = GLYPH_P;
                    right_m = GLYPH_A;
                end else begin
                    show_m  = c.track_is_go;
                    blink_m = 1'b0;
                end
            end
            MODE_DECIMAL: load_decimal(c.value, c.dp);
            MODE_RAW: begin
                left_m  = c.left_pattern;
                right_m = c.right_pattern;
            end
            default: ;
        endcase
        r = '{lines_m, left_on_m, right_on_m};
    endtask

    task automatic add_row(input logic [2:0] mode, input int value, input bit dp,
                           input bit pon, input bit go, input logic [7:0] lp,
                           input logic [7:0] rp, input bit typed, input logic [7:0] lines,
                           input bit le, input bit re);
        directed_row_t row;
        row.cmd   = '{mode, 16'(value), dp, pon, go, lp, rp};
        row.typed = typed;
        row.want  = '{lines, le, re};
        directed_rows.push_back(row);
    endtask

    // Operands for decimal and current-value commands: mostly in range, some just
    // outside it, and some across the whole signed field.
    function automatic logic signed [15:0] decimal_operand();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6) return 16'($urandom_range(99));
        if (pick < 8) return 16'(int'($urandom_range(400)) - 200);
        return 16'($urandom);
    endfunction

    // A random command. Ticks dominate so that every byte that is written ends up on
    // the lines, and pairing mostly starts, so that blinking is on for long stretches.
    function automatic item_t random_command();
        item_t c;
        int    pick;
        c.mode          = MODE_TICK;
        c.value         = 16'($urandom);
        c.dp            = 1'($urandom);
        c.pairing_on    = 1'($urandom);
        c.track_is_go   = 1'($urandom);
        c.left_pattern  = 8'($urandom);
        c.right_pattern = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 55) begin
            c.mode = MODE_TICK;
        end else if (pick < 63) begin
            c.mode = MODE_RAW;
        end else if (pick < 73) begin
            c.mode  = MODE_DECIMAL;
            c.value = decimal_operand();
        end else if (pick < 83) begin
            c.mode = MODE_STATUS;
            if ($urandom_range(3) != 0) c.value = 16'($urandom_range(7));
        end else if (pick < 91) begin
            c.mode  = MODE_CURRENT;
            c.value = decimal_operand();
        end else if (pick < 98) begin
            c.mode       = MODE_PAIRING;
            c.pairing_on = ($urandom_range(9) < 6);
        end else begin
            c.mode = $urandom_range(1) ? MODE_SPARE_6 : MODE_SPARE_7;
        end
        return c;
    endfunction

    // Offers one command, holds it until the transfer happens, then records what the
    // display should show afterwards. The task returns on the edge of the transfer, so
    // the next call drives s_valid at most once on that edge.
    task automatic send_command(input item_t c, input logic typed, input display_out_t want);
        display_out_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= c.mode;
        s_value         <= c.value;
        s_dp            <= c.dp;
        s_pairing_on    <= c.pairing_on;
        s_track_is_go   <= c.track_is_go;
        s_left_pattern  <= c.left_pattern;
        s_right_pattern <= c.right_pattern;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_display(c, predicted);
        pending_outputs.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // The blink period is written only while the driver is idle. Every command makes a
    // result, so an empty queue plus a wait for the two-stage pipeline to drain is enough.
    task automatic write_blink_period(input logic [11:0] p);
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        period_m = p;
        cfg_writes++;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        error_count++;
    endtask

    // Result side: every output transfer is checked against the oldest expectation.
    // The same process drives m_ready, either at random or held low for a long stretch
    // whenever the stimulus asks for back pressure.
    always @(posedge aclk) begin
        display_out_t got;
        display_out_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_segment_lines, m_left_enable, m_right_enable};
            results_seen++;
            if (pending_outputs.size() == 0) begin
                $display("%0t ns: output transfer with nothing expected, actual %0h %0b %0b",
                         $time, got.lines, got.left_en, got.right_en);
                error_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (got.lines !== want.lines)
                    report_mismatch("segment_lines", want.lines, got.lines);
                if (got.left_en !== want.left_en)
                    report_mismatch("left_enable", 8'(want.left_en), 8'(got.left_en));
                if (got.right_en !== want.right_en)
                    report_mismatch("right_enable", 8'(want.right_en), 8'(got.right_en));
            end
        end
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_requests != hold_served) begin
            m_ready <= 1'b0;
            hold_served++;
            hold_left = HOLD_OFF_CYCLES - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Stimulus: the directed table first, then random commands in phases that each
    // write a new blink period and use one of four patterns of idling.
    initial begin
        logic [11:0] periods [NUM_PHASES];

        // The periods cover the smallest legal one, the largest, and a drop from the
        // largest to 5 while the phase sits above it. Periods of 0 and 1 blank nothing.
        periods = '{12'd2, 12'd4095, 12'd5, 12'd0, 12'd1, 12'd3, 12'd16,
                    12'($urandom_range(4095, 2))};

        // The first rows walk the mux slots after reset. Those outputs can be read off
        // directly: slots 0 and 4 are off, 1-3 show the left byte, 5-7 the right one.
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h00, 0, 0);
        add_row(MODE_RAW,     0,      0, 0, 0, 8'hFF, 8'h00, 1, 8'h00, 0, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'hFF, 1, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'hFF, 1, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'hFF, 1, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'hFF, 0, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h00, 0, 1);
        // The largest number clamps to 99 with the point; the smallest clamps to a
        // blank zero. Writes leave the outputs as they were.
        add_row(MODE_DECIMAL, 32767,  1, 0, 0, 8'h00, 8'h00, 1, 8'h00, 0, 1);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h6F, 0, 1);
        add_row(MODE_DECIMAL, -32768, 0, 0, 0, 8'h00, 8'h00, 1, 8'h6F, 0, 1);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h3F, 0, 1);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h3F, 0, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 1, 8'h00, 1, 0);
        // A current value before GO is ignored, after GO it is shown with the point.
        add_row(MODE_CURRENT, 42,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_GO,        0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_CURRENT, 42,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_STOP,      0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_HALT,      0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_SHORT,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_TESTDRIVE, 0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_RESET,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  STATUS_OVERTEMP,  0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // Unknown status codes clear the shown value and keep the bytes.
        add_row(MODE_STATUS,  STATUS_OTHER,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_STATUS,  -1,     0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // Pairing blinks "PA"; this early in the period the tick is blanked.
        add_row(MODE_PAIRING, 0,      0, 1, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_TICK,    0,      0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_PAIRING, 0,      0, 0, 1, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        add_row(MODE_DECIMAL, 5,      1, 0, 0, 8'h00, 8'h00, 0, 8'h00, 0, 0);
        // A spare mode with every field set changes nothing.
        add_row(MODE_SPARE_7, -1,     1, 1, 1, 8'hFF, 8'hFF, 0, 8'h00, 0, 0);

        // Reset is held once, at the start of the run.
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_blink_period(periods[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // In the first phase the result side holds off for a long stretch while
                // commands keep coming, so the pipeline fills and s_ready drops.
                if (ph == 0 && n == HOLD_OFF_ITEM) hold_requests++;
                send_command(random_command(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d commands (directed table plus random phases) and %0d results,",
                 items_sent, results_seen);
        $display("with %0d blink period writes from 0 up to 4095 and four idling patterns.",
                 cfg_writes);
        if (error_count == 0 && pending_outputs.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: a correct run finishes far earlier than this.
    initial begin
        #2000000;
        $display("Timeout with %0d results still expected.", pending_outputs.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
